### rtl/dtpg_pkg.sv
// ----------------------------------------------------------------------------
// dtpg_pkg
// Shared types and constants for the dual tilemap pixel generator.
// ----------------------------------------------------------------------------
`default_nettype none

package dtpg_pkg;

  localparam int unsigned TILE_AW   = 11;
  localparam int unsigned CHAR_AW   = 13;
  localparam int unsigned DATA_W    = 8;
  localparam int unsigned CODE_W    = 9;
  localparam int unsigned ADDR_W    = 13;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [2:0] {
    KIND_BG_TILE = 3'd0,
    KIND_FG_TILE = 3'd1,
    KIND_BG_CHAR = 3'd2,
    KIND_FG_CHAR = 3'd3,
    KIND_RENDER  = 3'd4
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCROLL_X = 2'd0,
    CFG_SCROLL_Y = 2'd1,
    CFG_FLIP     = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic tile_we;
    logic char_we;
  } layer_wr_t;

  typedef struct packed {
    logic                draw;
    logic [DATA_W-1:0]   pen;
  } layer_px_t;

endpackage

`default_nettype wire

### rtl/dtpg_tile_ram.sv
// ----------------------------------------------------------------------------
// dtpg_tile_ram
// Tile map RAM: one write port, two registered read ports (attribute, code).
// ----------------------------------------------------------------------------
`default_nettype none

module dtpg_tile_ram (
  input  wire logic                           clk,
  input  wire logic                           we,
  input  wire logic [dtpg_pkg::TILE_AW-1:0]   waddr,
  input  wire logic [dtpg_pkg::DATA_W-1:0]    wdata,
  input  wire logic [dtpg_pkg::TILE_AW-1:0]   raddr_a,
  input  wire logic [dtpg_pkg::TILE_AW-1:0]   raddr_b,
  output      logic [dtpg_pkg::DATA_W-1:0]    rdata_a,
  output      logic [dtpg_pkg::DATA_W-1:0]    rdata_b
);

  localparam int unsigned DEPTH = 1 << dtpg_pkg::TILE_AW;

  logic [dtpg_pkg::DATA_W-1:0] mem_r [DEPTH];
  logic [dtpg_pkg::DATA_W-1:0] rdata_a_r;
  logic [dtpg_pkg::DATA_W-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_a_r <= mem_r[raddr_a];
    rdata_b_r <= mem_r[raddr_b];
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

`default_nettype wire

### rtl/dtpg_char_rom.sv
// ----------------------------------------------------------------------------
// dtpg_char_rom
// Character pattern store: one write port, two registered read ports
// (low and high bit plane).
// ----------------------------------------------------------------------------
`default_nettype none

module dtpg_char_rom (
  input  wire logic                           clk,
  input  wire logic                           we,
  input  wire logic [dtpg_pkg::CHAR_AW-1:0]   waddr,
  input  wire logic [dtpg_pkg::DATA_W-1:0]    wdata,
  input  wire logic [dtpg_pkg::CHAR_AW-1:0]   raddr_a,
  input  wire logic [dtpg_pkg::CHAR_AW-1:0]   raddr_b,
  output      logic [dtpg_pkg::DATA_W-1:0]    rdata_a,
  output      logic [dtpg_pkg::DATA_W-1:0]    rdata_b
);

  localparam int unsigned DEPTH = 1 << dtpg_pkg::CHAR_AW;

  logic [dtpg_pkg::DATA_W-1:0] mem_r [DEPTH];
  logic [dtpg_pkg::DATA_W-1:0] rdata_a_r;
  logic [dtpg_pkg::DATA_W-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_a_r <= mem_r[raddr_a];
    rdata_b_r <= mem_r[raddr_b];
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

`default_nettype wire

### rtl/dtpg_layer.sv
// ----------------------------------------------------------------------------
// dtpg_layer
// One tilemap layer: tile RAM lookup, character row fetch and pixel decode.
// Result is valid after the tile RAM read and the character row read, both registered.
// ----------------------------------------------------------------------------
`default_nettype none

module dtpg_layer (
  input  wire logic                           clk,
  input  wire dtpg_pkg::layer_wr_t            wr,
  input  wire logic [dtpg_pkg::ADDR_W-1:0]    waddr,
  input  wire logic [dtpg_pkg::DATA_W-1:0]    wdata,
  input  wire logic [7:0]                     tx,
  input  wire logic [7:0]                     ty,
  output      dtpg_pkg::layer_px_t            px
);

  logic [9:0]                   tile_idx;
  logic [dtpg_pkg::DATA_W-1:0]  attr_rd;
  logic [dtpg_pkg::DATA_W-1:0]  code_rd;
  logic [dtpg_pkg::DATA_W-1:0]  lo_rd;
  logic [dtpg_pkg::DATA_W-1:0]  hi_rd;
  logic [2:0]                   px0_r;
  logic [2:0]                   py0_r;
  logic [2:0]                   px1_r;
  logic [dtpg_pkg::DATA_W-1:0]  attr1_r;
  logic [dtpg_pkg::CODE_W-1:0]  code;
  logic [11:0]                  row;
  logic [2:0]                   bit_sel;
  logic [1:0]                   v;

  assign tile_idx = {ty[7:3], tx[7:3]};

  dtpg_tile_ram u_tile_ram (
    .clk     (clk),
    .we      (wr.tile_we),
    .waddr   (waddr[dtpg_pkg::TILE_AW-1:0]),
    .wdata   (wdata),
    .raddr_a ({1'b0, tile_idx}),
    .raddr_b ({1'b1, tile_idx}),
    .rdata_a (attr_rd),
    .rdata_b (code_rd)
  );

  always_ff @(posedge clk) begin
    px0_r   <= tx[2:0];
    py0_r   <= ty[2:0];
    px1_r   <= px0_r;
    attr1_r <= attr_rd;
  end

  assign code = {attr_rd[7], code_rd};
  assign row  = {code, py0_r};

  dtpg_char_rom u_char_rom (
    .clk     (clk),
    .we      (wr.char_we),
    .waddr   (waddr[dtpg_pkg::CHAR_AW-1:0]),
    .wdata   (wdata),
    .raddr_a ({1'b0, row}),
    .raddr_b ({1'b1, row}),
    .rdata_a (lo_rd),
    .rdata_b (hi_rd)
  );

  // bit 7 is the leftmost pixel
  assign bit_sel = ~px1_r;
  assign v       = {hi_rd[bit_sel], lo_rd[bit_sel]};

  always_comb begin
    px.draw = (v != 2'd0) || attr1_r[6];
    px.pen  = {attr1_r[5:0], v};
  end

endmodule

`default_nettype wire

### rtl/dual_tilemap_pixel_generator_core.sv
// ----------------------------------------------------------------------------
// dual_tilemap_pixel_generator_core
// Two-layer tilemap pixel generator with background scroll and screen flip.
//
// Usage: an item transfers on a rising edge with start high and busy low.
// in_kind selects a byte write into the background or foreground tile RAM
// or character store, or a render request for frame pixel (in_pixel_x,
// in_pixel_y). busy is held low: one item transfers every cycle.
// Each render request gives one pen on out_pen, marked by a one-cycle
// out_valid strobe after rv1_r, rv2_r, out_valid_r; writes give no result.
// Throughput is one item per clock, set by the two-port tile RAM and the
// two-port character store of each layer, each read once per item.
// The receiver takes every result as it appears and cannot hold it off.
// Configuration (scroll_x, scroll_y, flip_screen) is written through
// cfg_we / cfg_index / cfg_data with the pipeline idle.
// Reset clears the pipeline and the configuration registers; memory
// contents are not cleared and must be written before they are read.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_tilemap_pixel_generator_core #(
  parameter int unsigned FRAME_WIDTH  = 240,
  parameter int unsigned FRAME_HEIGHT = 192
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output      logic                              busy,
  input  wire logic [2:0]                        in_kind,
  input  wire logic [dtpg_pkg::ADDR_W-1:0]       in_addr,
  input  wire logic [dtpg_pkg::DATA_W-1:0]       in_data,
  input  wire logic [7:0]                        in_pixel_x,
  input  wire logic [7:0]                        in_pixel_y,
  output      logic                              out_valid,
  output      logic [dtpg_pkg::DATA_W-1:0]       out_pen,
  input  wire logic                              cfg_we,
  input  wire logic [dtpg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [dtpg_pkg::DATA_W-1:0]       cfg_data
);

  localparam logic [7:0] FW    = 8'(FRAME_WIDTH);
  localparam logic [7:0] FH    = 8'(FRAME_HEIGHT);
  localparam logic [7:0] FW_M1 = 8'(FRAME_WIDTH - 1);
  localparam logic [7:0] FH_M1 = 8'(FRAME_HEIGHT - 1);

  logic                          accept;
  logic                          render;
  logic                          in_frame;
  logic [7:0]                    fx;
  logic [7:0]                    fy;
  logic [7:0]                    tx;
  logic [7:0]                    ty;
  logic                          tile_wr_ok;
  dtpg_pkg::layer_wr_t           bg_wr;
  dtpg_pkg::layer_wr_t           fg_wr;
  dtpg_pkg::layer_px_t           bg_px;
  dtpg_pkg::layer_px_t           fg_px;
  logic [dtpg_pkg::DATA_W-1:0]   pen_nxt;

  logic [7:0]                    scroll_x_r;
  logic [7:0]                    scroll_y_r;
  logic                          flip_r;
  logic                          rv1_r;
  logic                          rv2_r;
  logic                          inf1_r;
  logic                          inf2_r;
  logic                          out_valid_r;
  logic [dtpg_pkg::DATA_W-1:0]   out_pen_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign render = accept && (in_kind == dtpg_pkg::KIND_RENDER);

  assign tile_wr_ok = (in_addr[dtpg_pkg::ADDR_W-1:dtpg_pkg::TILE_AW] == '0);

  always_comb begin
    bg_wr.tile_we = accept && (in_kind == dtpg_pkg::KIND_BG_TILE) && tile_wr_ok;
    bg_wr.char_we = accept && (in_kind == dtpg_pkg::KIND_BG_CHAR);
    fg_wr.tile_we = accept && (in_kind == dtpg_pkg::KIND_FG_TILE) && tile_wr_ok;
    fg_wr.char_we = accept && (in_kind == dtpg_pkg::KIND_FG_CHAR);
  end

  assign in_frame = (in_pixel_x < FW) && (in_pixel_y < FH);
  assign fx       = flip_r ? (FW_M1 - in_pixel_x) : in_pixel_x;
  assign fy       = flip_r ? (FH_M1 - in_pixel_y) : in_pixel_y;
  assign tx       = 8'd247 - fx;
  assign ty       = fy + 8'd32;

  dtpg_layer u_bg (
    .clk   (clk),
    .wr    (bg_wr),
    .waddr (in_addr),
    .wdata (in_data),
    .tx    (tx + scroll_x_r),
    .ty    (ty + scroll_y_r),
    .px    (bg_px)
  );

  dtpg_layer u_fg (
    .clk   (clk),
    .wr    (fg_wr),
    .waddr (in_addr),
    .wdata (in_data),
    .tx    (tx),
    .ty    (ty),
    .px    (fg_px)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scroll_x_r <= '0;
      scroll_y_r <= '0;
      flip_r     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        dtpg_pkg::CFG_SCROLL_X: scroll_x_r <= cfg_data;
        dtpg_pkg::CFG_SCROLL_Y: scroll_y_r <= cfg_data;
        dtpg_pkg::CFG_FLIP:     flip_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    pen_nxt = '0;
    if (inf2_r) begin
      if (fg_px.draw) begin
        pen_nxt = fg_px.pen;
      end else if (bg_px.draw) begin
        pen_nxt = bg_px.pen;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rv1_r       <= 1'b0;
      rv2_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rv1_r       <= render;
      rv2_r       <= rv1_r;
      out_valid_r <= rv2_r;
    end
  end

  always_ff @(posedge clk) begin
    inf1_r    <= in_frame;
    inf2_r    <= inf1_r;
    out_pen_r <= pen_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_pen   = out_pen_r;

  a_render_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_kind == dtpg_pkg::KIND_RENDER) |-> ##3 out_valid)
    else $error("render transfer gave no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy && in_kind == dtpg_pkg::KIND_RENDER) |-> ##3 !out_valid)
    else $error("result without render transfer");

  a_off_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (rv2_r && !inf2_r) |=> (out_pen_r == '0))
    else $error("pixel outside frame gave nonzero pen");

endmodule

`default_nettype wire
